// File: sv/fhg_pkg.sv
// Shared constants for the fire heat grid texture unit.
// Field widths, op codes and fixed-point reciprocals; no dependencies.
package fhg_pkg;

    localparam int GRID_WIDTH_DEF  = 16;
    localparam int GRID_HEIGHT_DEF = 20;

    localparam int OP_W    = 2;
    localparam int COL_W   = 4;
    localparam int SLOT_W  = 8;
    localparam int RAND_W  = 16;
    localparam int COLOR_W = 8;
    localparam int HEAT_W  = 16;
    localparam int MUL_W   = 32;

    localparam logic [OP_W-1:0] OP_STAGE = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // floor(2^32 / divisor) for the shared reciprocal divide
    localparam logic [31:0] RECIP_5   = 32'd858993459;
    localparam logic [31:0] RECIP_636 = 32'd6753093;
    localparam int          DIV_5     = 5;
    localparam int          DIV_636   = 636;

endpackage

// File: sv/fhg_in_if.sv
// Input channel of the fire heat grid texture unit.
// Depends on fhg_pkg for field widths.
interface fhg_in_if;
    logic                         valid;
    logic                         ready;
    logic [fhg_pkg::OP_W-1:0]     op;
    logic [fhg_pkg::COL_W-1:0]    column;
    logic [fhg_pkg::SLOT_W-1:0]   pixel_slot;
    logic [fhg_pkg::RAND_W-1:0]   rand_a;
    logic [fhg_pkg::RAND_W-1:0]   rand_b;
    logic [fhg_pkg::RAND_W-1:0]   rand_c;
    logic [fhg_pkg::RAND_W-1:0]   rand_d;

    modport source (output valid, op, column, pixel_slot, rand_a, rand_b, rand_c, rand_d,
                    input ready);
    modport sink   (input valid, op, column, pixel_slot, rand_a, rand_b, rand_c, rand_d,
                    output ready);
endinterface

// File: sv/fhg_out_if.sv
// Result channel of the fire heat grid texture unit.
// Depends on fhg_pkg for field widths.
interface fhg_out_if;
    logic                          valid;
    logic                          ready;
    logic [fhg_pkg::SLOT_W-1:0]    pixel_out;
    logic [fhg_pkg::COLOR_W-1:0]   red;
    logic [fhg_pkg::COLOR_W-1:0]   green;
    logic [fhg_pkg::COLOR_W-1:0]   blue;
    logic [fhg_pkg::COLOR_W-1:0]   alpha;

    modport source (output valid, pixel_out, red, green, blue, alpha, input ready);
    modport sink   (input valid, pixel_out, red, green, blue, alpha, output ready);
endinterface

// File: sv/fhg_mul.sv
// Shared registered multiplier of the fire heat grid texture unit.
// Depends on fhg_pkg for the operand width.
module fhg_mul (
    input  logic                            i_clk,
    input  logic [fhg_pkg::MUL_W-1:0]       i_a,
    input  logic [fhg_pkg::MUL_W-1:0]       i_b,
    output logic [2*fhg_pkg::MUL_W-1:0]     o_p
);
    logic [2*fhg_pkg::MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// File: sv/fire_heat_grid_texture_unit.sv
// Fire heat grid texture unit: a GRID_WIDTH x GRID_HEIGHT Q3.13 heat grid in a
// two-bank memory, run by a sequencer around one shared 32x32 multiplier.
// After reset a clearing pass zeroes the grid and no item is taken. A column stage
// computes one staged heat value; a pixel read first reduces pixel_slot modulo the
// cell count by repeated subtraction and holds its result while the previous one
// still waits at the output; a frame advance computes each cell of the upper
// GRID_HEIGHT-1 rows from six reads, then writes the staged row into the bottom row.
// The single memory read port (six reads per cell) and the shared multiplier limit
// the throughput. One item is in work at a time.
module fire_heat_grid_texture_unit #(
    parameter int GRID_WIDTH  = fhg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = fhg_pkg::GRID_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fhg_in_if.sink      i_in,
    fhg_out_if.source   o_out
);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int CW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int NW    = 26;
    localparam int HW    = fhg_pkg::HEAT_W;
    localparam int MW    = fhg_pkg::MUL_W;
    localparam int MEM_D = 2 ** (CW + 1);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_ST0    = 5'd2;
    localparam logic [4:0] S_ST1    = 5'd3;
    localparam logic [4:0] S_ST2    = 5'd4;
    localparam logic [4:0] S_ST_WR  = 5'd5;
    localparam logic [4:0] S_DV_MUL = 5'd6;
    localparam logic [4:0] S_DV_FIX = 5'd7;
    localparam logic [4:0] S_FR_RD  = 5'd8;
    localparam logic [4:0] S_FR_ACC = 5'd9;
    localparam logic [4:0] S_FR_WR  = 5'd10;
    localparam logic [4:0] S_FR_BOT = 5'd11;
    localparam logic [4:0] S_PX_MOD = 5'd12;
    localparam logic [4:0] S_PX_RD  = 5'd13;
    localparam logic [4:0] S_PX_H   = 5'd14;
    localparam logic [4:0] S_PX_F   = 5'd15;
    localparam logic [4:0] S_PX_P2  = 5'd16;
    localparam logic [4:0] S_PX_P4  = 5'd17;
    localparam logic [4:0] S_PX_P8  = 5'd18;
    localparam logic [4:0] S_PX_P10 = 5'd19;
    localparam logic [4:0] S_PX_OUT = 5'd20;

    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_ONE  = 2'd1;
    localparam logic [1:0] W_19   = 2'd2;

    logic [4:0]  r_state, n_state;
    logic [4:0]  r_ret;
    logic        r_div636;
    logic        r_bank;
    logic [CW-1:0] r_clr;

    logic [fhg_pkg::COL_W-1:0]  r_col;
    logic [fhg_pkg::SLOT_W-1:0] r_slot;
    logic [fhg_pkg::SLOT_W-1:0] r_slot_m;
    logic [fhg_pkg::SLOT_W-1:0] r_po;
    logic [fhg_pkg::RAND_W-1:0] r_ra;
    logic [fhg_pkg::RAND_W-1:0] r_rb;
    logic [fhg_pkg::RAND_W-1:0] r_rc;
    logic [fhg_pkg::RAND_W-1:0] r_rd;

    logic [HW-1:0] r_staged [GRID_WIDTH];
    logic [HW-1:0] r_mem [MEM_D];
    logic [HW-1:0] r_rd_data;

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [2:0]    r_tap;
    logic [1:0]    r_pw;
    logic [20:0]   r_acc;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quot;
    logic [16:0]   r_f;
    logic [16:0]   r_p2;
    logic [33:0]   r_ff;

    logic                          r_ov;
    logic [fhg_pkg::COLOR_W-1:0]   r_red, r_green, r_blue, r_alpha;
    logic [fhg_pkg::COLOR_W-1:0]   r_pr, r_pg, r_pb, r_pa;

    logic [MW-1:0]   w_ma, w_mb;
    logic [2*MW-1:0] w_p;
    logic            w_wr_en;
    logic [CW:0]     w_wr_addr;
    logic [HW-1:0]   w_wr_data;
    logic [CW:0]     w_rd_addr;
    logic [1:0]      w_tap_w;
    logic [20:0]     w_contrib;
    logic [20:0]     w_sum;
    logic [NW-1:0]   w_q;
    logic [16:0]     w_f;
    logic [56:0]     w_t;
    logic [16:0]     w_p10;

    fhg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.pixel_out = r_po;
    assign o_out.red       = r_red;
    assign o_out.green     = r_green;
    assign o_out.blue      = r_blue;
    assign o_out.alpha     = r_alpha;

    // reciprocal divide fix-up, memory read address, frame tap weights and pixel-path terms
    always_comb begin
        int         nx, ny;
        logic [NW:0] q0, rem, dv;
        logic        ok;
        q0  = {1'b0, w_p[NW+31:32]};
        dv  = r_div636 ? (NW+1)'(fhg_pkg::DIV_636) : (NW+1)'(fhg_pkg::DIV_5);
        rem = {1'b0, r_num} - (NW+1)'(q0 * dv);
        w_q = (rem >= dv) ? NW'(q0 + 1'b1) : NW'(q0);

        nx = int'(r_x);
        ny = int'(r_y);
        ok = 1'b1;
        w_tap_w = W_ONE;
        case (r_tap)
            3'd0: begin ny = ny + 1; w_tap_w = W_19; end
            3'd1: begin end
            3'd2: begin nx = nx - 1; ok = (r_x != '0); end
            3'd3: begin nx = nx + 1; ok = (int'(r_x) != GRID_WIDTH - 1); end
            3'd4: begin nx = nx - 1; ny = ny + 1; ok = (r_x != '0); end
            default: begin nx = nx + 1; ny = ny + 1; ok = (int'(r_x) != GRID_WIDTH - 1); end
        endcase
        if (!ok) begin
            w_tap_w = W_NONE;
            nx = int'(r_x);
        end

        w_rd_addr = {r_bank, CW'(ny * GRID_WIDTH + nx)};
        if (r_state == S_PX_RD) begin
            w_rd_addr = {r_bank, CW'(r_slot_m)};
        end

        case (r_pw)
            W_19:    w_contrib = 21'({r_rd_data, 4'b0}) + 21'({r_rd_data, 1'b0})
                                 + 21'(r_rd_data);
            W_ONE:   w_contrib = 21'(r_rd_data);
            default: w_contrib = '0;
        endcase
        w_sum = r_acc + w_contrib;

        w_f = (r_quot > NW'(65536)) ? 17'd65536 : r_quot[16:0];
        w_t = 57'({w_p[47:0], 6'b0}) + 57'({w_p[47:0], 4'b0})
              + 57'({(18'(r_rd) + 18'd131072), 33'b0});
        w_p10 = w_p[32:16];
    end

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_ST0:    begin w_ma = MW'(r_ra); w_mb = MW'(r_rb); end
            S_ST1:    begin w_ma = w_p[MW-1:0]; w_mb = MW'(r_rc); end
            S_DV_MUL: begin
                w_ma = MW'(r_num);
                w_mb = r_div636 ? fhg_pkg::RECIP_636 : fhg_pkg::RECIP_5;
            end
            S_PX_F:   begin w_ma = MW'(w_f); w_mb = MW'(w_f); end
            S_PX_P2, S_PX_P4: begin w_ma = MW'(w_p[32:16]); w_mb = MW'(w_p[32:16]); end
            S_PX_P8:  begin w_ma = MW'(w_p[32:16]); w_mb = MW'(r_p2); end
            default:  begin end
        endcase
    end

    // memory write port
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = '0;
        unique case (r_state)
            S_CLEAR:  begin w_wr_en = 1'b1; w_wr_addr = {1'b0, r_clr}; end
            S_FR_WR:  begin
                w_wr_en   = 1'b1;
                w_wr_addr = {~r_bank, CW'(int'(r_y) * GRID_WIDTH + int'(r_x))};
                w_wr_data = r_quot[HW-1:0];
            end
            S_FR_BOT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = {~r_bank, CW'((GRID_HEIGHT - 1) * GRID_WIDTH + int'(r_x))};
                w_wr_data = r_staged[r_x];
            end
            default:  begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (int'(r_clr) == CELLS - 1) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.op)
                        fhg_pkg::OP_STAGE:
                            n_state = (int'(i_in.column) < GRID_WIDTH) ? S_ST0 : S_IDLE;
                        fhg_pkg::OP_FRAME: n_state = S_FR_RD;
                        fhg_pkg::OP_PIXEL: n_state = S_PX_MOD;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_ST0:    n_state = S_ST1;
            S_ST1:    n_state = S_ST2;
            S_ST2:    n_state = S_DV_MUL;
            S_ST_WR:  n_state = S_IDLE;
            S_DV_MUL: n_state = S_DV_FIX;
            S_DV_FIX: n_state = r_ret;
            S_FR_RD:  if (r_tap == 3'd5) n_state = S_FR_ACC;
            S_FR_ACC: n_state = S_DV_MUL;
            S_FR_WR: begin
                if (int'(r_x) == GRID_WIDTH - 1 && int'(r_y) == GRID_HEIGHT - 2) begin
                    n_state = S_FR_BOT;
                end else begin
                    n_state = S_FR_RD;
                end
            end
            S_FR_BOT: if (int'(r_x) == GRID_WIDTH - 1) n_state = S_IDLE;
            S_PX_MOD: if (int'(r_slot_m) < CELLS) n_state = S_PX_RD;
            S_PX_RD:  n_state = S_PX_H;
            S_PX_H:   n_state = S_DV_MUL;
            S_PX_F:   n_state = S_PX_P2;
            S_PX_P2:  n_state = S_PX_P4;
            S_PX_P4:  n_state = S_PX_P8;
            S_PX_P8:  n_state = S_PX_P10;
            S_PX_P10: n_state = S_PX_OUT;
            S_PX_OUT: if (!r_ov || o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_bank   <= 1'b0;
            r_ov     <= 1'b0;
            r_ret    <= S_IDLE;
            r_div636 <= 1'b0;
            r_tap    <= '0;
            r_pw     <= W_NONE;
            for (int i = 0; i < GRID_WIDTH; i++) begin
                r_staged[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready && r_state != S_PX_OUT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_col    <= i_in.column;
                    r_slot   <= i_in.pixel_slot;
                    r_slot_m <= i_in.pixel_slot;
                    r_ra     <= i_in.rand_a;
                    r_rb     <= i_in.rand_b;
                    r_rc     <= i_in.rand_c;
                    r_rd     <= i_in.rand_d;
                    r_x      <= '0;
                    r_y      <= '0;
                    r_tap    <= '0;
                    r_pw     <= W_NONE;
                    r_acc    <= '0;
                end
                S_ST2: begin
                    r_num    <= NW'(w_t[56:37]);
                    r_div636 <= 1'b0;
                    r_ret    <= S_ST_WR;
                end
                S_ST_WR: begin
                    for (int i = 0; i < GRID_WIDTH; i++) begin
                        if (int'(r_col) == i) begin
                            r_staged[i] <= r_quot[HW-1:0];
                        end
                    end
                end
                S_DV_FIX: r_quot <= w_q;
                S_FR_RD: begin
                    r_acc <= w_sum;
                    r_pw  <= w_tap_w;
                    r_tap <= r_tap + 1'b1;
                end
                S_FR_ACC: begin
                    r_num    <= NW'({w_sum, 4'b0}) + NW'({w_sum, 3'b0}) + NW'(w_sum);
                    r_div636 <= 1'b1;
                    r_ret    <= S_FR_WR;
                end
                S_FR_WR: begin
                    r_acc <= '0;
                    r_tap <= '0;
                    r_pw  <= W_NONE;
                    if (int'(r_x) == GRID_WIDTH - 1) begin
                        r_x <= '0;
                        if (int'(r_y) != GRID_HEIGHT - 2) begin
                            r_y <= r_y + 1'b1;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_FR_BOT: begin
                    r_x <= r_x + 1'b1;
                    if (int'(r_x) == GRID_WIDTH - 1) begin
                        r_bank <= ~r_bank;
                    end
                end
                S_PX_MOD: begin
                    if (int'(r_slot_m) >= CELLS) begin
                        r_slot_m <= r_slot_m - fhg_pkg::SLOT_W'(CELLS);
                    end
                end
                S_PX_H: begin
                    r_num    <= NW'({r_rd_data, 6'b0}) + NW'({r_rd_data, 3'b0});
                    r_div636 <= 1'b0;
                    r_ret    <= S_PX_F;
                end
                S_PX_F:  r_f <= w_f;
                S_PX_P2: begin
                    r_ff <= w_p[33:0];
                    r_p2 <= w_p[32:16];
                end
                S_PX_P10: begin
                    r_pr <= 8'((25'({r_f, 7'b0}) + 25'({r_f, 4'b0}) + 25'({r_f, 3'b0})
                                + 25'({r_f, 1'b0}) + 25'(r_f)) >> 16) + 8'd100;
                    r_pg <= 8'((42'({r_ff, 8'b0}) - 42'(r_ff)) >> 32);
                    r_pb <= 8'((25'({w_p10, 8'b0}) - 25'(w_p10)) >> 16);
                    r_pa <= r_f[16] || r_f[15] ? 8'd255 : 8'd0;
                end
                S_PX_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_po    <= r_slot;
                        r_red   <= r_pr;
                        r_green <= r_pg;
                        r_blue  <= r_pb;
                        r_alpha <= r_pa;
                    end
                end
                default: begin end
            endcase
        end
    end

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input taken during clearing pass");

    a_result_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == S_PX_OUT))
        else $error("result raised outside pixel read");

    a_bank_flip_at_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bank != $past(r_bank)) |-> ($past(r_state) == S_FR_BOT))
        else $error("bank flipped outside frame end");
endmodule
